@@ rtl/core/rcpfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpfa_pkg - shared types and codes of the page frame allocator
// Request and error codes, the command beat from front to back and the
// result beat from back to the result queue.
// ----------------------------------------------------------------------------
package rcpfa_pkg;

  localparam int unsigned NumPagesDef  = 4096;
  localparam int unsigned PageBytesDef = 4096;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned LimW   = 25;
  localparam int unsigned NumW   = 13;
  localparam int unsigned CntW   = 13;
  localparam int unsigned RefW   = 8;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned ErrW   = 3;
  // page index / page counter width in the command; holds any index derived
  // from a 24-bit address plus one, and any page count of a 25-bit length
  localparam int unsigned CurW   = 25;

  typedef enum logic [ReqW-1:0] {
    REQ_ADD     = 3'd0,
    REQ_RESERVE = 3'd1,
    REQ_ANY     = 3'd2,
    REQ_ADDREF  = 3'd3,
    REQ_FREE    = 3'd4,
    REQ_CONTIG  = 3'd5
  } req_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE         = 3'd0,
    ERR_NO_PAGES     = 3'd1,
    ERR_RSV_UNUSABLE = 3'd2,
    ERR_REF_UNUSABLE = 3'd3,
    ERR_FREE_BAD     = 3'd4,
    ERR_REF_OVERFLOW = 3'd5
  } err_e;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic [CurW-1:0] idx;   // first page of the request
    logic [CurW-1:0] cnt;   // pages to walk, or run length for contiguous
  } cmd_t;

  typedef struct packed {
    logic             ok;
    logic [ErrW-1:0]  err;
    logic [AddrW-1:0] paddr;
    logic [RefW-1:0]  ref_after;
    logic [CntW-1:0]  free_pages;
    logic [CntW-1:0]  total_pages;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/refcounted_page_frame_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator - page frame allocator with reference counts
// Next-fit and contiguous page allocation over a table of usable bits and
// 8-bit reference counts, behind queue-style request and result ports.
// ----------------------------------------------------------------------------
// Requests enter through a two-beat command queue (push/full) and results
// leave through a two-beat result queue (pop/empty), one result per request,
// in order. After reset the block sweeps its page table, one page a cycle,
// so full stays high until the sweep is done, before the first request is taken.
// The back end handles one request at a time and touches one table entry
// per step, through a single registered read port: add ref and free read
// the entry and then update it; add range marks one page usable per step;
// reserve reads and checks each page, then clears the pages in a second
// pass; alloc any reads and checks pages from the next-fit point, at most
// once around the table; alloc contiguous scans from page 0, then claims the
// pages of the run. Free and total page counts saturate at 8191.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator #(
  parameter int unsigned NUM_PAGES  = rcpfa_pkg::NumPagesDef,
  parameter int unsigned PAGE_BYTES = rcpfa_pkg::PageBytesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [rcpfa_pkg::ReqW-1:0]   req_type_i,
  input  wire logic [rcpfa_pkg::AddrW-1:0]  byte_addr_i,
  input  wire logic [rcpfa_pkg::LimW-1:0]   range_limit_i,
  input  wire logic [rcpfa_pkg::NumW-1:0]   page_count_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              ok_o,
  output logic [rcpfa_pkg::ErrW-1:0]        error_code_o,
  output logic [rcpfa_pkg::AddrW-1:0]       page_addr_o,
  output logic [rcpfa_pkg::RefW-1:0]        ref_after_o,
  output logic [rcpfa_pkg::CntW-1:0]        free_pages_o,
  output logic [rcpfa_pkg::CntW-1:0]        total_pages_o
);
  import rcpfa_pkg::*;

  cmd_t cmd;
  logic cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full, clearing;
  logic [$bits(res_t)-1:0] res_rdata;

  // front: classify and queue requests; held off while the table clears
  rcpfa_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .hold_i        (clearing),
    .req_type_i    (req_type_i),
    .byte_addr_i   (byte_addr_i),
    .range_limit_i (range_limit_i),
    .page_count_i  (page_count_i),
    .cmd_pop_i     (cmd_pop),
    .cmd_o         (cmd),
    .cmd_empty_o   (cmd_empty)
  );

  // back: walk the page table; start a command only with a result slot free
  rcpfa_back #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  // result queue: decouple the consumer from the sequencer
  rcpfa_fifo #(
    .DataW ($bits(res_t)),
    .Depth (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out       = res_t'(res_rdata);
  assign ok_o          = res_out.ok;
  assign error_code_o  = res_out.err;
  assign page_addr_o   = res_out.paddr;
  assign ref_after_o   = res_out.ref_after;
  assign free_pages_o  = res_out.free_pages;
  assign total_pages_o = res_out.total_pages;

  // a success beat never carries an error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ok_o) |-> (error_code_o == ERR_NONE))
    else $error("success result with error code");

  // a failed request never reports a page address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !ok_o) |-> (page_addr_o == '0))
    else $error("failed result with page address");

  // no result can appear while the table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (empty && !res_push))
    else $error("result during table clear");

  // the sequencer never pushes into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !$past(res_full) || $past(pop))
    else $error("result pushed into full queue");

endmodule
`default_nettype wire

@@ rtl/core/rcpfa_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpfa_fifo - short register queue
// Small first-in first-out queue with full/empty flags.
// ----------------------------------------------------------------------------
module rcpfa_fifo #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [DataW-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic [DataW-1:0]      rdata_o,
  output logic                  empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [FillW-1:0] fill_q;
  logic             do_wr, do_rd;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (do_rd) rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      if (do_wr && !do_rd) fill_q <= fill_q + 1'b1;
      else if (do_rd && !do_wr) fill_q <= fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wdata_i;
  end

endmodule
`default_nettype wire

@@ rtl/core/rcpfa_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpfa_front - request intake and classification
// Turns a byte range into a first page and a page count, or takes the page
// count of a contiguous request, and queues the command for the back end.
// ----------------------------------------------------------------------------
module rcpfa_front #(
  parameter int unsigned PAGE_BYTES = rcpfa_pkg::PageBytesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         hold_i,
  input  wire logic [rcpfa_pkg::ReqW-1:0]   req_type_i,
  input  wire logic [rcpfa_pkg::AddrW-1:0]  byte_addr_i,
  input  wire logic [rcpfa_pkg::LimW-1:0]   range_limit_i,
  input  wire logic [rcpfa_pkg::NumW-1:0]   page_count_i,
  input  wire logic                         cmd_pop_i,
  output rcpfa_pkg::cmd_t                   cmd_o,
  output logic                              cmd_empty_o
);
  import rcpfa_pkg::*;

  localparam int unsigned OffW = $clog2(PAGE_BYTES);

  cmd_t            cmd;
  logic [OffW-1:0] off;
  logic [CurW-1:0] idx, head, len, rbegin;
  logic [CurW:0]   span;
  logic            q_full, q_wr;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    off    = byte_addr_i[OffW-1:0];
    idx    = CurW'(byte_addr_i >> OffW);
    head   = CurW'(PAGE_BYTES) - CurW'(off);
    len    = '0;
    rbegin = CurW'(byte_addr_i) & ~CurW'(PAGE_BYTES - 1);
    span   = (CurW + 1)'(range_limit_i - rbegin) + (CurW + 1)'(PAGE_BYTES - 1);
    cmd.req = req_type_i;
    cmd.idx = idx;
    cmd.cnt = '0;
    case (req_type_i)
      REQ_ADD: begin
        // skip the partial first page
        if (off != '0) begin
          cmd.idx = idx + 1'b1;
          if (range_limit_i >= head) begin
            len     = range_limit_i - head;
            cmd.cnt = len >> OffW;
          end
        end else begin
          cmd.cnt = range_limit_i >> OffW;
        end
      end
      REQ_RESERVE: begin
        if (range_limit_i > rbegin) cmd.cnt = CurW'(span >> OffW);
      end
      REQ_CONTIG: begin
        cmd.idx = '0;
        cmd.cnt = CurW'(page_count_i);
      end
      default: begin
        cmd.cnt = '0;
      end
    endcase
  end

  assign full  = q_full || hold_i;
  assign q_wr  = push && !full;
  assign cmd_o = cmd_t'(q_rdata);

  rcpfa_fifo #(
    .DataW ($bits(cmd_t)),
    .Depth (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (cmd),
    .full_o  (q_full),
    .rd_i    (cmd_pop_i),
    .rdata_o (q_rdata),
    .empty_o (cmd_empty_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/rcpfa_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpfa_back - page table sequencer
// Holds the usable and reference count tables and walks them one page per
// step to carry out each command.
// ----------------------------------------------------------------------------
module rcpfa_back #(
  parameter int unsigned NUM_PAGES  = rcpfa_pkg::NumPagesDef,
  parameter int unsigned PAGE_BYTES = rcpfa_pkg::PageBytesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rcpfa_pkg::cmd_t   cmd_i,
  input  wire logic              cmd_empty_i,
  output logic                   cmd_pop_o,
  input  wire logic              res_full_i,
  output logic                   res_push_o,
  output rcpfa_pkg::res_t        res_o,
  output logic                   clearing_o
);
  import rcpfa_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_PAGES);
  localparam int unsigned OffW = $clog2(PAGE_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD, S_RSV_RD, S_RSV_EV, S_RSV_WR, S_ANY_RD, S_ANY_EV,
    S_ONE_RD, S_ONE_EV, S_CON_RD, S_CON_EV, S_CON_WR
  } state_e;

  function automatic logic [CntW-1:0] inc_sat(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [CntW-1:0] dec_sat(input logic [CntW-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  logic       usable_mem [NUM_PAGES];
  logic [RefW-1:0] ref_mem [NUM_PAGES];
  logic            u_rd_q;
  logic [RefW-1:0] r_rd_q;
  logic            u_we, u_wd, r_we;
  logic [RefW-1:0] r_wd;
  logic [IdxW-1:0] maddr;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CurW-1:0] cur_q, cur_d, rem_q, rem_d, start_q, start_d;
  logic [NumW-1:0] run_q, run_d, run_n;
  logic [IdxW-1:0] nfi_q, nfi_d;
  logic [CntW-1:0] free_q, free_d, total_q, total_d;
  logic            is_free;
  res_t            res;

  assign maddr      = cur_q[IdxW-1:0];
  assign is_free    = u_rd_q && (r_rd_q == '0);
  assign clearing_o = (state_q == S_CLEAR);
  assign res_o      = res;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cur_d     = cur_q;
    rem_d     = rem_q;
    start_d   = start_q;
    run_d     = run_q;
    run_n     = '0;
    nfi_d     = nfi_q;
    free_d    = free_q;
    total_d   = total_q;
    u_we      = 1'b0;
    u_wd      = 1'b0;
    r_we      = 1'b0;
    r_wd      = '0;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res       = '0;
    case (state_q)
      S_CLEAR: begin
        u_we = 1'b1;
        r_we = 1'b1;
        if (cur_q == CurW'(NUM_PAGES - 1)) begin
          cur_d   = '0;
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cur_d     = cmd_i.idx;
          rem_d     = cmd_i.cnt;
          run_d     = '0;
          case (cmd_i.req)
            REQ_ADD:     state_d = S_ADD;
            REQ_RESERVE: state_d = S_RSV_RD;
            REQ_ANY: begin
              cur_d   = CurW'(nfi_q);
              rem_d   = CurW'(NUM_PAGES);
              state_d = S_ANY_RD;
            end
            REQ_ADDREF, REQ_FREE: begin
              if (cmd_i.idx >= CurW'(NUM_PAGES)) begin
                res_push_o = 1'b1;
                res.err = (cmd_i.req == REQ_ADDREF) ? ERR_REF_UNUSABLE : ERR_FREE_BAD;
              end else begin
                state_d = S_ONE_RD;
              end
            end
            REQ_CONTIG: begin
              if (cmd_i.cnt == '0 || cmd_i.cnt > CurW'(NUM_PAGES)) begin
                res_push_o = 1'b1;
                res.err    = ERR_NO_PAGES;
              end else begin
                cur_d   = '0;
                state_d = S_CON_RD;
              end
            end
            default: res_push_o = 1'b1;
          endcase
        end
      end
      S_ADD: begin
        if (rem_q == '0 || cur_q >= CurW'(NUM_PAGES)) begin
          res_push_o = 1'b1;
          res.ok     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          u_we    = 1'b1;
          u_wd    = 1'b1;
          total_d = inc_sat(total_q);
          free_d  = inc_sat(free_q);
          cur_d   = cur_q + 1'b1;
          rem_d   = rem_q - 1'b1;
        end
      end
      S_RSV_RD: begin
        // check every page first, then clear in a second pass
        if (rem_q == '0) begin
          cur_d   = cmd_q.idx;
          rem_d   = cmd_q.cnt;
          state_d = S_RSV_WR;
        end else if (cur_q >= CurW'(NUM_PAGES)) begin
          res_push_o = 1'b1;
          res.err    = ERR_RSV_UNUSABLE;
          state_d    = S_IDLE;
        end else begin
          state_d = S_RSV_EV;
        end
      end
      S_RSV_EV: begin
        if (!u_rd_q) begin
          res_push_o = 1'b1;
          res.err    = ERR_RSV_UNUSABLE;
          state_d    = S_IDLE;
        end else begin
          cur_d   = cur_q + 1'b1;
          rem_d   = rem_q - 1'b1;
          state_d = S_RSV_RD;
        end
      end
      S_RSV_WR: begin
        if (rem_q == '0) begin
          res_push_o = 1'b1;
          res.ok     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          u_we   = 1'b1;
          free_d = dec_sat(free_q);
          cur_d  = cur_q + 1'b1;
          rem_d  = rem_q - 1'b1;
        end
      end
      S_ANY_RD: begin
        if (rem_q == '0) begin
          res_push_o = 1'b1;
          res.err    = ERR_NO_PAGES;
          state_d    = S_IDLE;
        end else begin
          state_d = S_ANY_EV;
        end
      end
      S_ANY_EV: begin
        if (is_free) begin
          r_we       = 1'b1;
          r_wd       = RefW'(1);
          nfi_d      = maddr;
          free_d     = dec_sat(free_q);
          res_push_o = 1'b1;
          res.ok     = 1'b1;
          res.ref_after = RefW'(1);
          res.paddr  = AddrW'(cur_q << OffW);
          state_d    = S_IDLE;
        end else begin
          cur_d   = (cur_q == CurW'(NUM_PAGES - 1)) ? '0 : cur_q + 1'b1;
          rem_d   = rem_q - 1'b1;
          state_d = S_ANY_RD;
        end
      end
      S_ONE_RD: state_d = S_ONE_EV;
      S_ONE_EV: begin
        res_push_o    = 1'b1;
        res.ref_after = r_rd_q;
        state_d       = S_IDLE;
        if (cmd_q.req == REQ_ADDREF) begin
          if (!u_rd_q) begin
            res.err = ERR_REF_UNUSABLE;
          end else if (r_rd_q == '1) begin
            res.err = ERR_REF_OVERFLOW;
          end else begin
            r_we          = 1'b1;
            r_wd          = r_rd_q + 1'b1;
            if (r_rd_q == '0) free_d = dec_sat(free_q);
            res.ok        = 1'b1;
            res.ref_after = r_wd;
            res.paddr     = AddrW'(cur_q << OffW);
          end
        end else begin
          if (!u_rd_q || r_rd_q == '0) begin
            res.err = ERR_FREE_BAD;
          end else begin
            r_we          = 1'b1;
            r_wd          = r_rd_q - 1'b1;
            if (r_rd_q == RefW'(1)) free_d = inc_sat(free_q);
            res.ok        = 1'b1;
            res.ref_after = r_wd;
          end
        end
      end
      S_CON_RD: begin
        if (cur_q >= CurW'(NUM_PAGES)) begin
          res_push_o = 1'b1;
          res.err    = ERR_NO_PAGES;
          state_d    = S_IDLE;
        end else begin
          state_d = S_CON_EV;
        end
      end
      S_CON_EV: begin
        run_n = is_free ? run_q + 1'b1 : '0;
        run_d = run_n;
        if (CurW'(run_n) == cmd_q.cnt) begin
          start_d = cur_q + 1'b1 - cmd_q.cnt;
          cur_d   = cur_q + 1'b1 - cmd_q.cnt;
          rem_d   = cmd_q.cnt;
          state_d = S_CON_WR;
        end else begin
          cur_d   = cur_q + 1'b1;
          state_d = S_CON_RD;
        end
      end
      S_CON_WR: begin
        if (rem_q == '0) begin
          res_push_o    = 1'b1;
          res.ok        = 1'b1;
          res.ref_after = RefW'(1);
          res.paddr     = AddrW'(start_q << OffW);
          state_d       = S_IDLE;
        end else begin
          r_we   = 1'b1;
          r_wd   = RefW'(1);
          free_d = dec_sat(free_q);
          cur_d  = cur_q + 1'b1;
          rem_d  = rem_q - 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res.free_pages  = free_d;
    res.total_pages = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cur_q   <= '0;
      rem_q   <= '0;
      start_q <= '0;
      run_q   <= '0;
      nfi_q   <= '0;
      free_q  <= '0;
      total_q <= '0;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      rem_q   <= rem_d;
      start_q <= start_d;
      run_q   <= run_d;
      nfi_q   <= nfi_d;
      free_q  <= free_d;
      total_q <= total_d;
      cmd_q   <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_we) usable_mem[maddr] <= u_wd;
    if (r_we) ref_mem[maddr] <= r_wd;
    u_rd_q <= usable_mem[maddr];
    r_rd_q <= ref_mem[maddr];
  end

endmodule
`default_nettype wire
